### rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants of the serial command line decoder
// Byte classes, event and command codes, the command word table and the
// word types that pass between the decoder's parts.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

  // Event codes of a result word
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_ECHO     = 3'd1;
  localparam logic [2:0] EV_ERASE    = 3'd2;
  localparam logic [2:0] EV_TOO_LONG = 3'd3;
  localparam logic [2:0] EV_DONE     = 3'd4;

  // Command codes of a result word
  localparam logic [2:0] CMD_BALANCE     = 3'd0;
  localparam logic [2:0] CMD_STOP_ALL    = 3'd1;
  localparam logic [2:0] CMD_START_PRINT = 3'd2;
  localparam logic [2:0] CMD_STOP_PRINT  = 3'd3;
  localparam logic [2:0] CMD_MENU        = 3'd4;
  localparam logic [2:0] CMD_CLEAR       = 3'd5;
  localparam logic [2:0] CMD_INVALID     = 3'd6;

  // Character codes
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [6:0] CH_LOWER_C = 7'h63;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_NINE    = 7'h39;
  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_UPPER_Z = 7'h5A;
  localparam logic [6:0] CASE_DELTA = 7'h20;

  localparam logic [6:0] MAX_CELL_RESET = 7'd16;

  // Fixed command words, checked in this order after the balance command
  localparam int NUM_WORDS = 5;
  localparam logic [2:0] WORD_R        = 3'd0;
  localparam logic [2:0] WORD_STARTAFE = 3'd1;
  localparam logic [2:0] WORD_STOPAFE  = 3'd2;
  localparam logic [2:0] WORD_MENU     = 3'd3;
  localparam logic [2:0] WORD_C        = 3'd4;

  typedef enum logic [1:0] {
    CLS_IGNORE,
    CLS_PRINT,
    CLS_ERASE,
    CLS_END
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [6:0]  data;
  } item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] command;
    logic [6:0] target_cell;
    logic [7:0] echo_byte;
  } result_t;

  // Word text, left aligned, zero padded.
  function automatic logic [63:0] word_text(input logic [2:0] w);
    logic [63:0] text;
    begin
      unique case (w)
        WORD_R:        text = {"r", 56'h0};
        WORD_STARTAFE: text = "startafe";
        WORD_STOPAFE:  text = {"stopafe", 8'h0};
        WORD_MENU:     text = {"menu", 32'h0};
        WORD_C:        text = {"c", 56'h0};
        default:       text = '0;
      endcase
      return text;
    end
  endfunction

  function automatic logic [3:0] word_len(input logic [2:0] w);
    logic [3:0] n;
    begin
      unique case (w)
        WORD_R:        n = 4'd1;
        WORD_STARTAFE: n = 4'd8;
        WORD_STOPAFE:  n = 4'd7;
        WORD_MENU:     n = 4'd4;
        WORD_C:        n = 4'd1;
        default:       n = 4'd0;
      endcase
      return n;
    end
  endfunction

  function automatic logic [2:0] word_command(input logic [2:0] w);
    logic [2:0] c;
    begin
      unique case (w)
        WORD_R:        c = CMD_STOP_ALL;
        WORD_STARTAFE: c = CMD_START_PRINT;
        WORD_STOPAFE:  c = CMD_STOP_PRINT;
        WORD_MENU:     c = CMD_MENU;
        WORD_C:        c = CMD_CLEAR;
        default:       c = CMD_INVALID;
      endcase
      return c;
    end
  endfunction

  function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] k);
    logic [63:0] shifted;
    begin
      shifted = word_text(w) << {k, 3'b000};
      return shifted[63:56];
    end
  endfunction

  function automatic logic [6:0] low_case(input logic [6:0] ch);
    logic [6:0] r;
    begin
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
        r = ch + CASE_DELTA;
      end else begin
        r = ch;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/scd_in_if.sv
// ----------------------------------------------------------------------------
// scd_in_if: received byte channel
// Valid/ready channel that carries one received serial byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface scd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/scd_out_if.sv
// ----------------------------------------------------------------------------
// scd_out_if: decoder result channel
// Valid/ready channel that carries one decoder result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface scd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [2:0] command;
  logic [6:0] target_cell;
  logic [7:0] echo_byte;

  modport source (output valid, output event_res, output command, output target_cell,
                  output echo_byte, input ready);
  modport sink (input valid, input event_res, input command, input target_cell,
                input echo_byte, output ready);
endinterface

`default_nettype wire

### rtl/scd_front.sv
// ----------------------------------------------------------------------------
// scd_front: byte classifier
// Accepts received bytes and registers each with its class: printable,
// erase, line end or ignored control byte.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_front
  import scd_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  scd_in_if.sink     byte_ch,
  output item_t      item,
  output logic       item_valid,
  input  wire        item_ready
);

  logic        hold_valid;
  item_t       hold;
  item_t       classified;
  logic        accept;

  assign byte_ch.ready = !hold_valid || item_ready;
  assign accept        = byte_ch.valid && byte_ch.ready;

  always_comb begin
    classified.data = byte_ch.rx_byte[6:0];
    priority if (byte_ch.rx_byte == CH_CR || byte_ch.rx_byte == CH_LF) begin
      classified.cls = CLS_END;
    end else if (byte_ch.rx_byte == CH_BS || byte_ch.rx_byte == CH_DEL) begin
      classified.cls = CLS_ERASE;
    end else if (byte_ch.rx_byte >= CH_SPACE && byte_ch.rx_byte <= CH_TILDE) begin
      classified.cls = CLS_PRINT;
    end else begin
      classified.cls = CLS_IGNORE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (item_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= classified;
    end
  end

  assign item       = hold;
  assign item_valid = hold_valid;

endmodule

`default_nettype wire

### rtl/scd_queue.sv
// ----------------------------------------------------------------------------
// scd_queue: two-word queue between classifier and line engine
// Small first-in first-out buffer of classified bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_queue
  import scd_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  wire   pop_ready
);

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

### rtl/scd_back.sv
// ----------------------------------------------------------------------------
// scd_back: line engine
// Keeps the edited line in a small memory, applies each classified byte and
// scans the line one character a cycle at a line end to find the command.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_back
  import scd_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire  [6:0] max_cell,
  input  wire        pop_valid,
  input  item_t      pop_item,
  output logic       pop_ready,
  scd_out_if.source  result_ch
);

  localparam int STORE_DEPTH = LINE_DEPTH - 1;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(LINE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                 state, state_next;
  logic [LEN_W-1:0]       len, len_next;
  logic [LEN_W-1:0]       rd_idx, rd_idx_next;
  logic                   ev_valid, ev_valid_next;
  logic [LEN_W-1:0]       ev_idx;
  logic                   ok_bal, ok_bal_next;
  logic [NUM_WORDS-1:0]   ok_word, ok_word_next;
  logic [6:0]             value, value_next;
  logic                   out_valid, out_valid_next;
  result_t                res, res_next;

  logic [6:0]             line_store [STORE_DEPTH];
  logic [6:0]             rdata;
  logic                   mem_we;
  logic                   rd_en;

  logic                   out_free;
  logic [8:0]             pos;
  logic [6:0]             lc;
  logic [10:0]            value_wide;
  logic                   is_balance;
  logic [2:0]             found_cmd;
  result_t                done_res;

  assign out_free = !out_valid || result_ch.ready;
  assign pos      = 9'(ev_idx);
  assign lc       = low_case(rdata);
  assign value_wide = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + 11'(rdata - CH_ZERO);

  // Final decision from the flags gathered during the scan.
  always_comb begin
    is_balance = ok_bal && (len >= LEN_W'(2)) && (value != 7'd0);
    found_cmd  = CMD_INVALID;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (ok_word[i] && (9'(len) == 9'(word_len(3'(i))))) begin
        found_cmd = word_command(3'(i));
      end
    end
    done_res             = '0;
    done_res.event_res   = EV_DONE;
    if (is_balance) begin
      done_res.command     = CMD_BALANCE;
      done_res.target_cell = value;
    end else begin
      done_res.command     = found_cmd;
    end
  end

  always_comb begin
    state_next     = state;
    len_next       = len;
    rd_idx_next    = rd_idx;
    ev_valid_next  = 1'b0;
    ok_bal_next    = ok_bal;
    ok_word_next   = ok_word;
    value_next     = value;
    out_valid_next = out_valid && !result_ch.ready;
    res_next       = res;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    pop_ready      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (pop_valid && out_free) begin
          pop_ready      = 1'b1;
          out_valid_next = 1'b1;
          res_next       = '0;
          unique case (pop_item.cls)
            CLS_PRINT: begin
              if (len < LEN_W'(STORE_DEPTH)) begin
                mem_we             = 1'b1;
                len_next           = len + LEN_W'(1);
                res_next.event_res = EV_ECHO;
                res_next.echo_byte = {1'b0, pop_item.data};
              end else begin
                len_next           = '0;
                res_next.event_res = EV_TOO_LONG;
              end
            end
            CLS_ERASE: begin
              if (len != '0) begin
                len_next           = len - LEN_W'(1);
                res_next.event_res = EV_ERASE;
              end
            end
            CLS_END: begin
              if (len != '0) begin
                // The result is produced after the scan instead.
                out_valid_next = out_valid && !result_ch.ready;
                res_next       = res;
                state_next     = S_SCAN;
                rd_idx_next    = '0;
                ok_bal_next    = 1'b1;
                ok_word_next   = '1;
                value_next     = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_idx < len) begin
          rd_en         = 1'b1;
          rd_idx_next   = rd_idx + LEN_W'(1);
          ev_valid_next = 1'b1;
        end
        if (ev_valid) begin
          for (int i = 0; i < NUM_WORDS; i++) begin
            if (pos < 9'(word_len(3'(i))) &&
                {1'b0, lc} != word_char(3'(i), pos[2:0])) begin
              ok_word_next[i] = 1'b0;
            end
          end
          if (pos == 9'd0) begin
            if (lc != CH_LOWER_C) begin
              ok_bal_next = 1'b0;
            end
          end else if (rdata < CH_ZERO || rdata > CH_NINE) begin
            ok_bal_next = 1'b0;
          end else begin
            if (value_wide > 11'(max_cell)) begin
              ok_bal_next = 1'b0;
            end
            value_next = value_wide[6:0];
          end
          // The flags keep their failure once set, so a garbage value later on
          // does not matter.
          if (!ok_bal) begin
            ok_bal_next = 1'b0;
          end
          if (ev_idx == LEN_W'(len - LEN_W'(1))) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          res_next       = done_res;
          len_next       = '0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      rd_idx    <= '0;
      ev_valid  <= 1'b0;
      ok_bal    <= 1'b0;
      ok_word   <= '0;
      value     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      rd_idx    <= rd_idx_next;
      ev_valid  <= ev_valid_next;
      ok_bal    <= ok_bal_next;
      ok_word   <= ok_word_next;
      value     <= value_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res    <= res_next;
    ev_idx <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[len[IDX_W-1:0]] <= pop_item.data;
    end
    if (rd_en) begin
      rdata <= line_store[rd_idx[IDX_W-1:0]];
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.event_res   = res.event_res;
  assign result_ch.command     = res.command;
  assign result_ch.target_cell = res.target_cell;
  assign result_ch.echo_byte   = res.echo_byte;

endmodule

`default_nettype wire

### rtl/serial_command_line_decoder.sv
// ----------------------------------------------------------------------------
// serial_command_line_decoder: edited command line and command matcher
//
//   channel     dir  handshake      payload
//   byte_ch     in   valid/ready    rx_byte[7:0]
//   result_ch   out  valid/ready    event_res[2:0] command[2:0]
//                                   target_cell[6:0] echo_byte[7:0]
//   wr_en       in   write enable   wr_data[6:0] (max_cell)
//
// A byte that edits the line yields its result word in the cycle after it
// reaches the line engine. A line end scans the stored line through the
// single read port of the line memory, one character a cycle, and gives its
// result word once the scan ends and the result channel is free. A two-word
// queue sits between classifier and line engine, so bytes are taken while a
// result waits. Reset is synchronous; the line memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_line_decoder
  import scd_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  wire        clk,
  input  wire        rst,
  scd_in_if.sink     byte_ch,
  scd_out_if.source  result_ch,
  input  wire        wr_en,
  input  wire  [6:0] wr_data
);

  logic [6:0] max_cell;
  item_t      front_item;
  logic       front_valid;
  logic       front_ready;
  item_t      queue_item;
  logic       queue_valid;
  logic       queue_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cell <= MAX_CELL_RESET;
    end else if (wr_en) begin
      max_cell <= wr_data;
    end
  end

  scd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  scd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_item  (front_item),
    .push_ready (front_ready),
    .pop_valid  (queue_valid),
    .pop_item   (queue_item),
    .pop_ready  (queue_ready)
  );

  scd_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_cell  (max_cell),
    .pop_valid (queue_valid),
    .pop_item  (queue_item),
    .pop_ready (queue_ready),
    .result_ch (result_ch)
  );

endmodule

`default_nettype wire
